// ===== rtl/midpoint_circle_point_generator_macros.svh =====
// assertion helpers shared by the rtl files
// every module that asserts has i_clk and the active-low i_rst_n
`ifndef MIDPOINT_CIRCLE_POINT_GENERATOR_MACROS_SVH
`define MIDPOINT_CIRCLE_POINT_GENERATOR_MACROS_SVH

// same-cycle implication
`define MCPG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MCPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mcpg_pkg.sv =====
package mcpg_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 10;

    // input item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // points emitted per group
    localparam int NUM_POINTS = 8;

    // group queue depth between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // decision constants of the midpoint method
    localparam int DEC_START  = 3;
    localparam int DEC_INC_X  = 6;
    localparam int DEC_INC_XY = 10;

endpackage

// ===== rtl/mcpg_front.sv =====
`include "midpoint_circle_point_generator_macros.svh"

module mcpg_front #(
    parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_kind,
    input  logic [COORD_BITS-1:0]   i_center_x,
    input  logic [COORD_BITS-1:0]   i_center_y,
    input  logic [COORD_BITS-2:0]   i_radius,
    output logic                    o_push,
    output logic [4*COORD_BITS+1:0] o_desc,
    input  logic                    i_full
);
    import mcpg_pkg::*;

    localparam int DecBits = COORD_BITS + 4;
    localparam int CmpBits = COORD_BITS + 2;

    logic                      r_active, n_active;
    logic [COORD_BITS-1:0]     r_x, n_x;
    logic [COORD_BITS:0]       r_y, n_y;
    logic signed [DecBits-1:0] r_d, n_d;
    logic [COORD_BITS-1:0]     r_cx, n_cx;
    logic [COORD_BITS-1:0]     r_cy, n_cy;

    logic                      w_accept;
    logic                      w_done;
    logic signed [DecBits-1:0] w_xe, w_ye;
    logic signed [CmpBits-1:0] w_nx, w_ny;

    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && !i_full;

    // classify the transaction and advance the offsets
    always_comb begin
        n_active = r_active;
        n_x      = r_x;
        n_y      = r_y;
        n_d      = r_d;
        n_cx     = r_cx;
        n_cy     = r_cy;
        o_push   = 1'b0;
        w_xe     = signed'(DecBits'(r_x));
        w_ye     = signed'(DecBits'(r_y));
        if (w_accept) begin
            if (i_kind == KIND_START) begin
                n_cx     = i_center_x;
                n_cy     = i_center_y;
                n_x      = '0;
                n_y      = (COORD_BITS+1)'(i_radius);
                n_d      = signed'(DecBits'(DEC_START))
                           - (signed'(DecBits'(i_radius)) <<< 1);
                n_active = 1'b1;
                o_push   = 1'b1;
            end else if (r_active) begin
                if (r_d[DecBits-1]) begin
                    n_d = r_d + (w_xe <<< 2) + signed'(DecBits'(DEC_INC_X));
                end else begin
                    n_d = r_d + ((w_xe - w_ye) <<< 2)
                          + signed'(DecBits'(DEC_INC_XY));
                    n_y = r_y - 1'b1;
                end
                n_x    = r_x + 1'b1;
                o_push = 1'b1;
            end
        end
        // would the following step carry x past y
        w_nx = signed'(CmpBits'(n_x)) + signed'(CmpBits'(1));
        w_ny = signed'(CmpBits'(n_y))
               - signed'(CmpBits'(n_d[DecBits-1] ? 1'b0 : 1'b1));
        w_done = w_nx > w_ny;
        if (o_push && w_done) begin
            n_active = 1'b0;
        end
    end

    assign o_desc = {w_done, n_y, n_x, n_cy, n_cx};

    // circle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_x      <= '0;
            r_y      <= '0;
            r_d      <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
        end else begin
            r_active <= n_active;
            r_x      <= n_x;
            r_y      <= n_y;
            r_d      <= n_d;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
        end
    end

    `MCPG_ASSERT_NEXT(a_idle_step_stays_idle,
        w_accept && i_kind == KIND_STEP && !r_active, !r_active && $stable(r_x),
        "step while idle changed state")

endmodule

// ===== rtl/mcpg_queue.sv =====
`include "midpoint_circle_point_generator_macros.svh"

module mcpg_queue #(
    parameter int WIDTH = 42
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import mcpg_pkg::*;

    localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]   r_mem [QUEUE_DEPTH];
    logic [PtrBits-1:0] r_wptr, r_rptr;
    logic [CntBits-1:0] r_count;

    assign o_full  = (r_count == CntBits'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `MCPG_ASSERT_IMPL(a_push_not_full, i_push, !o_full, "push into full queue")
    `MCPG_ASSERT_IMPL(a_pop_not_empty, i_pop, !o_empty, "pop from empty queue")

endmodule

// ===== rtl/mcpg_back.sv =====
`include "midpoint_circle_point_generator_macros.svh"

module mcpg_back #(
    parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    output logic                         o_pop,
    input  logic [4*COORD_BITS+1:0]      i_desc,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_BITS+1:0] o_point_x,
    output logic signed [COORD_BITS+1:0] o_point_y,
    output logic                         o_group_last,
    output logic                         o_circle_done
);
    import mcpg_pkg::*;

    localparam int PtBits = COORD_BITS + 2;
    localparam int KBits  = $clog2(NUM_POINTS);

    // group being emitted
    logic                  r_cur_valid;
    logic [COORD_BITS-1:0] r_cx, r_cy, r_x;
    logic [COORD_BITS:0]   r_y;
    logic                  r_cur_done;
    logic [KBits-1:0]      r_k;

    // output register
    logic                     r_out_valid;
    logic signed [PtBits-1:0] r_px, r_py;
    logic                     r_last, r_done;

    logic                     w_load, w_emit, w_end;
    logic signed [PtBits-1:0] w_a, w_b, w_px, w_py;

    assign w_load = !r_out_valid || i_out_ready;
    assign w_emit = w_load && r_cur_valid;
    assign w_end  = w_emit && (r_k == KBits'(NUM_POINTS - 1));
    assign o_pop  = (!r_cur_valid || w_end) && !i_empty;

    // octant point k: x offset on points 0,3,4,7 else y, mirrored as k walks round
    always_comb begin
        if (r_k[0] ^ r_k[1]) begin
            w_a = signed'(PtBits'(r_y));
            w_b = signed'(PtBits'(r_x));
        end else begin
            w_a = signed'(PtBits'(r_x));
            w_b = signed'(PtBits'(r_y));
        end
        w_px = r_k[2] ? signed'(PtBits'(r_cx)) - w_a : signed'(PtBits'(r_cx)) + w_a;
        w_py = (r_k[2] ^ r_k[1]) ? signed'(PtBits'(r_cy)) - w_b
                                 : signed'(PtBits'(r_cy)) + w_b;
    end

    // group load and point counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
            end else if (w_end) begin
                r_cur_valid <= 1'b0;
            end
            if (w_emit) begin
                r_k <= w_end ? '0 : r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            {r_cur_done, r_y, r_x, r_cy, r_cx} <= i_desc;
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (w_load) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_px   <= w_px;
            r_py   <= w_py;
            r_last <= w_end;
            r_done <= w_end && r_cur_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_x     = r_px;
    assign o_point_y     = r_py;
    assign o_group_last  = r_last;
    assign o_circle_done = r_done;

    `MCPG_ASSERT_IMPL(a_done_on_last, r_out_valid && r_done, r_last,
        "circle done off the last point of a group")
    `MCPG_ASSERT_IMPL(a_count_needs_group, r_k != '0, r_cur_valid,
        "point counter running without a group")
    `MCPG_ASSERT_NEXT(a_pop_loads_group, o_pop, r_cur_valid && r_k == '0,
        "popped group not loaded")

endmodule

// ===== rtl/midpoint_circle_point_generator.sv =====
// Midpoint circle rasterizer. A start transaction (kind 0) latches center and radius
// and yields the eight symmetric points of offset (0, r); each step transaction
// (kind 1) advances the offsets by one midpoint step and yields the next eight
// points, the eighth flagged group_last, and circle_done on the final point of the
// circle. A step while no circle is open is accepted and yields nothing.
// The front takes one transaction per cycle while the queue is not full and works out
// the new offsets at once; groups wait in a two-entry queue, and the back writes one
// point per cycle into an output register unless the output stalls. A start
// transaction's first point passes through the queue, the back's group register and
// the output register.
module midpoint_circle_point_generator #(
    parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_kind,
    input  logic [COORD_BITS-1:0]        i_center_x,
    input  logic [COORD_BITS-1:0]        i_center_y,
    input  logic [COORD_BITS-2:0]        i_radius,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_BITS+1:0] o_point_x,
    output logic signed [COORD_BITS+1:0] o_point_y,
    output logic                         o_group_last,
    output logic                         o_circle_done
);
    localparam int DescBits = 4 * COORD_BITS + 2;

    logic                w_push, w_pop, w_full, w_empty;
    logic [DescBits-1:0] w_push_desc, w_pop_desc;

    // front: accept and advance
    mcpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .o_push     (w_push),
        .o_desc     (w_push_desc),
        .i_full     (w_full)
    );

    // group queue
    mcpg_queue #(
        .WIDTH (DescBits)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_desc),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_desc),
        .o_empty (w_empty)
    );

    // back: emit eight points per group
    mcpg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .i_desc        (w_pop_desc),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_group_last  (o_group_last),
        .o_circle_done (o_circle_done)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import mcpg_pkg::*;

    localparam int COORD_BITS  = COORD_BITS_DEF;
    localparam int PT_BITS     = COORD_BITS + 2;
    localparam int RANDOM_ITEMS = 200;
    localparam int MAX_WAIT    = 19;
    localparam int SETTLE      = 24;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic signed [PT_BITS-1:0] px;
        logic signed [PT_BITS-1:0] py;
        logic                      grp_last;
        logic                      done;
    } t_point;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic                         i_kind = KIND_START;
    logic [COORD_BITS-1:0]        i_center_x = '0;
    logic [COORD_BITS-1:0]        i_center_y = '0;
    logic [COORD_BITS-2:0]        i_radius = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [PT_BITS-1:0]    o_point_x;
    logic signed [PT_BITS-1:0]    o_point_y;
    logic                         o_group_last;
    logic                         o_circle_done;

    // rasterizer state as the block should hold it
    logic [COORD_BITS-1:0]        off_x = '0;
    logic [COORD_BITS:0]          off_y = '0;
    logic signed [COORD_BITS+3:0] dec = '0;
    logic [COORD_BITS-1:0]        hold_cx = '0;
    logic [COORD_BITS-1:0]        hold_cy = '0;
    logic                         circle_open = 1'b0;

    t_point pending_points[$];
    int     errors = 0;
    int     idle_cycles = 0;
    int     out_stall = 0;
    bit     in_calm = 1'b0;
    bit     out_calm = 1'b0;

    midpoint_circle_point_generator #(
        .COORD_BITS(COORD_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_group_last (o_group_last),
        .o_circle_done(o_circle_done)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic void push_point(int px, int py, bit grp_last, bit done);
        t_point pt;
        pt.px       = px[PT_BITS-1:0];
        pt.py       = py[PT_BITS-1:0];
        pt.grp_last = grp_last;
        pt.done     = done;
        pending_points.push_back(pt);
    endfunction

    // eight symmetric points of the current offsets, flags on the eighth
    function automatic void emit_octants();
        int cx, cy, x, y;
        bit closing;
        cx = int'(hold_cx);
        cy = int'(hold_cy);
        x  = int'(off_x);
        y  = int'(off_y);
        // circle ends when the following step would take x past y
        closing = (x + 1) > ((dec >= 0) ? y - 1 : y);
        push_point(cx + x, cy + y, 1'b0, 1'b0);
        push_point(cx + y, cy + x, 1'b0, 1'b0);
        push_point(cx + y, cy - x, 1'b0, 1'b0);
        push_point(cx + x, cy - y, 1'b0, 1'b0);
        push_point(cx - x, cy - y, 1'b0, 1'b0);
        push_point(cx - y, cy - x, 1'b0, 1'b0);
        push_point(cx - y, cy + x, 1'b0, 1'b0);
        push_point(cx - x, cy + y, 1'b1, closing);
        if (closing)
            circle_open = 1'b0;
    endfunction

    // midpoint update for one accepted transaction
    function automatic void predict_points(logic kind, logic [COORD_BITS-1:0] cx_in,
                                           logic [COORD_BITS-1:0] cy_in,
                                           logic [COORD_BITS-2:0] r_in);
        int x, y, d;
        if (kind == KIND_START) begin
            hold_cx     = cx_in;
            hold_cy     = cy_in;
            off_x       = '0;
            off_y       = {2'b00, r_in};
            d           = DEC_START - 2 * int'(r_in);
            dec         = d[COORD_BITS+3:0];
            circle_open = 1'b1;
            emit_octants();
        end else if (circle_open) begin
            x = int'(off_x);
            y = int'(off_y);
            d = int'(dec);
            if (d < 0) begin
                d += 4 * x + DEC_INC_X;
            end else begin
                d += 4 * (x - y) + DEC_INC_XY;
                y -= 1;
            end
            x += 1;
            off_x = x[COORD_BITS-1:0];
            off_y = y[COORD_BITS:0];
            dec   = d[COORD_BITS+3:0];
            emit_octants();
        end
    endfunction

    // one input transaction: optional gap, then hold valid until accepted
    task automatic send_item(logic kind, logic [COORD_BITS-1:0] cx,
                             logic [COORD_BITS-1:0] cy, logic [COORD_BITS-2:0] r);
        int gap;
        gap = draw_wait(in_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius   <= r;
        // ready as seen at the edge itself
        @(posedge i_clk iff o_in_ready);
        predict_points(kind, cx, cy, r);
    endtask

    // start a circle and step it until it closes or max_steps are taken
    task automatic draw_circle(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                               logic [COORD_BITS-2:0] r, int max_steps, inout int count);
        int steps;
        steps = 0;
        send_item(KIND_START, cx, cy, r);
        count++;
        while (circle_open && steps < max_steps) begin
            send_item(KIND_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                      (COORD_BITS-1)'($urandom));
            steps++;
            count++;
        end
    endtask

    task automatic test_idle_steps();
        send_item(KIND_STEP, '1, '1, '1);
        send_item(KIND_STEP, '0, '0, '0);
    endtask

    task automatic test_zero_radius();
        int count;
        count = 0;
        draw_circle('0, '0, '0, 0, count);
        send_item(KIND_STEP, '0, '0, '0);
        draw_circle('1, '1, '0, 0, count);
    endtask

    task automatic test_small_circles();
        int count;
        count = 0;
        draw_circle(10'd512, 10'd512, 9'd1, 4, count);
        send_item(KIND_STEP, '1, '0, '1);
        draw_circle(10'd100, 10'd900, 9'd3, 8, count);
        draw_circle(10'd7, 10'd1000, 9'd5, 8, count);
    endtask

    // full-radius circles at both corners, each abandoned by a new start
    task automatic test_extreme_circles();
        int count;
        count = 0;
        draw_circle('0, '0, '1, 3, count);
        draw_circle('1, '1, '1, 3, count);
        draw_circle(10'h2aa, 10'h155, 9'd2, 0, count);
    endtask

    task automatic test_random_circles();
        int sent, sel, max_steps;
        logic [COORD_BITS-2:0] r;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0)
                in_calm = !in_calm;
            sel = int'($urandom_range(0, 9));
            if (sel == 0) begin
                // stray step, ignored unless a circle happens to be open
                if (circle_open)
                    sent++;
                send_item(KIND_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                          (COORD_BITS-1)'($urandom));
            end else begin
                r = ($urandom_range(0, 3) != 0) ? (COORD_BITS-1)'($urandom_range(0, 48))
                                                : (COORD_BITS-1)'($urandom);
                if (sel == 1)
                    max_steps = int'($urandom_range(0, 5));
                else if (r > 60)
                    max_steps = int'($urandom_range(0, 30));
                else
                    max_steps = 1000;
                draw_circle(COORD_BITS'($urandom), COORD_BITS'($urandom), r, max_steps,
                            sent);
            end
        end
        in_calm = 1'b0;
    endtask

    // result side: random stalls, compare against the oldest predicted point
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_points.size() == 0) begin
                    $error("point (%0d,%0d) with nothing expected", o_point_x, o_point_y);
                    errors++;
                end else begin
                    t_point pt;
                    pt = pending_points.pop_front();
                    if (o_point_x !== pt.px) begin
                        $error("point_x expected %0d actual %0d", pt.px, o_point_x);
                        errors++;
                    end
                    if (o_point_y !== pt.py) begin
                        $error("point_y expected %0d actual %0d", pt.py, o_point_y);
                        errors++;
                    end
                    if (o_group_last !== pt.grp_last) begin
                        $error("group_last expected %0d actual %0d", pt.grp_last,
                               o_group_last);
                        errors++;
                    end
                    if (o_circle_done !== pt.done) begin
                        $error("circle_done expected %0d actual %0d", pt.done,
                               o_circle_done);
                        errors++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    out_calm = !out_calm;
                out_stall = draw_wait(out_calm);
            end else if (out_stall > 0) begin
                out_stall--;
            end
            i_out_ready <= (out_stall == 0);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_steps();
        test_zero_radius();
        test_small_circles();
        test_extreme_circles();
        test_random_circles();

        i_in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
